// ===== hdl/chb_pkg.sv =====
// Shared constants and types of the CRC-32 mix bucket hash unit.
package chb_pkg;

   localparam int TABLE_SIZE = 1024;
   localparam int KEY_W      = 8;
   localparam int BUCKET_W   = 10;
   localparam int CRC_W      = 32;
   localparam int MIX_W      = 64;
   localparam int HASH_W     = 16;

   localparam logic [CRC_W-1:0]  CRC_POLY      = 32'hEDB8_8320;
   localparam logic [MIX_W-1:0]  KNUTH_MULT    = 64'd2654435761;
   localparam logic [HASH_W-1:0] KNUTH_MULT_LO = KNUTH_MULT[HASH_W-1:0];
   localparam logic [HASH_W-1:0] TABLE_MASK    = HASH_W'(TABLE_SIZE - 1);

   typedef struct packed {
      logic             valid;
      logic [MIX_W-1:0] key;
   } mix_stage_type;

endpackage

// ===== hdl/chb_ifs.sv =====
// Valid/ready channel interfaces for key bytes and bucket results.
interface chb_req_if;
   logic                       valid;
   logic                       ready;
   logic [chb_pkg::KEY_W-1:0]  key_byte;
   logic                       last_byte;

   modport source (output valid, output key_byte, output last_byte, input ready);
   modport sink (input valid, input key_byte, input last_byte, output ready);
endinterface

interface chb_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [chb_pkg::BUCKET_W-1:0] bucket_index;

   modport source (output valid, output bucket_index, input ready);
   modport sink (input valid, input bucket_index, output ready);
endinterface

// ===== hdl/chb_crc.sv =====
// Running reflected CRC-32 over key bytes and the stage that captures a finished key.
module chb_crc (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic                      advance,
   input  logic [chb_pkg::KEY_W-1:0] key_byte,
   input  logic                      last_byte,
   output chb_pkg::mix_stage_type    crc_out
);
   import chb_pkg::*;

   function automatic logic [CRC_W-1:0] crc_step(input logic [CRC_W-1:0] crc,
                                                 input logic [KEY_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = {{(CRC_W-KEY_W){1'b0}}, crc[KEY_W-1:0] ^ data};
      for (int i = 0; i < KEY_W; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c ^ (crc >> KEY_W);
   endfunction

   logic [CRC_W-1:0] crc_ff;
   logic [CRC_W-1:0] crc_in;
   logic [CRC_W-1:0] crc_next;
   mix_stage_type    stage_ff;
   mix_stage_type    stage_in;

   always_comb begin
      crc_next = crc_step(crc_ff, key_byte);
      crc_in   = crc_ff;
      if (accept) begin
         crc_in = last_byte ? '0 : crc_next;
      end
      stage_in.valid = accept && last_byte;
      stage_in.key   = {{(MIX_W-CRC_W){1'b0}}, crc_next};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff         <= '0;
         stage_ff.valid <= 1'b0;
      end else begin
         crc_ff <= crc_in;
         if (advance) begin
            stage_ff <= stage_in;
         end
      end
   end

   assign crc_out = stage_ff;

   a_crc_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      accept && last_byte |=> crc_ff == '0)
      else $error("crc not cleared after last byte");

   a_crc_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !accept |=> $stable(crc_ff))
      else $error("crc changed without an item");

   a_stage_only_on_last: assert property (@(posedge clock) disable iff (reset)
      advance && !(accept && last_byte) |=> !stage_ff.valid)
      else $error("stage valid without a last byte");

endmodule

// ===== hdl/chb_mix.sv =====
// Two-stage 64-bit integer mix of the finished CRC.
module chb_mix (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   advance,
   input  chb_pkg::mix_stage_type mix_in,
   output chb_pkg::mix_stage_type mix_out
);
   import chb_pkg::*;

   mix_stage_type    first_ff;
   mix_stage_type    first_in;
   mix_stage_type    second_ff;
   mix_stage_type    second_in;
   logic [MIX_W-1:0] ka;
   logic [MIX_W-1:0] kb;

   always_comb begin
      ka = mix_in.key;
      ka = ka + (ka << 12);
      ka = ka ^ (ka >> 22);
      ka = ka + (ka << 4);
      ka = ka ^ (ka >> 9);
      first_in.valid = mix_in.valid;
      first_in.key   = ka;

      kb = first_ff.key;
      kb = kb + (kb << 10);
      kb = kb ^ (kb >> 2);
      kb = kb + (kb << 7);
      kb = kb ^ (kb >> 12);
      second_in.valid = first_ff.valid;
      second_in.key   = kb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff.valid  <= 1'b0;
         second_ff.valid <= 1'b0;
      end else if (advance) begin
         first_ff  <= first_in;
         second_ff <= second_in;
      end
   end

   assign mix_out = second_ff;

endmodule

// ===== hdl/chb_out.sv =====
// Multiplicative hash, table reduction and result register.
module chb_out (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  chb_pkg::mix_stage_type       mix_in,
   output logic                         out_valid,
   output logic [chb_pkg::BUCKET_W-1:0] bucket_index
);
   import chb_pkg::*;

   logic [HASH_W-1:0]   prod;
   logic                valid_ff;
   logic                valid_in;
   logic [BUCKET_W-1:0] index_ff;
   logic [BUCKET_W-1:0] index_in;

   always_comb begin
      prod     = mix_in.key[HASH_W+2:3] * KNUTH_MULT_LO;
      index_in = BUCKET_W'(prod & TABLE_MASK);
      valid_in = mix_in.valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         index_ff <= index_in;
      end
   end

   assign out_valid    = valid_ff;
   assign bucket_index = index_ff;

   a_out_follows_stage: assert property (@(posedge clock) disable iff (reset)
      advance |=> valid_ff == $past(valid_in))
      else $error("result valid lost or invented");

   a_out_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(valid_ff) && $stable(index_ff))
      else $error("result changed during stall");

endmodule

// ===== hdl/crc32_mix_bucket_hash_unit.sv =====
// Bucket hash of byte-string keys: reflected CRC-32, 64-bit integer mix, Knuth multiply.
// Takes one key byte per cycle with no gaps while the result channel does not stall; the
// running CRC is a table-free loop, which sets that rate. The bucket index of a key passes
// through the CRC capture register, then two mix stages, then the multiply into the result
// register. A stalled result stalls the whole pipe, including input.
module crc32_mix_bucket_hash_unit (
   input logic       clock,
   input logic       reset,
   chb_req_if.sink   req_chan,
   chb_rsp_if.source rsp_chan
);
   import chb_pkg::*;

   logic          advance;
   logic          accept;
   mix_stage_type crc_stage;
   mix_stage_type mix_stage;

   assign advance        = !rsp_chan.valid || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;

   chb_crc u_crc (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .advance   (advance),
      .key_byte  (req_chan.key_byte),
      .last_byte (req_chan.last_byte),
      .crc_out   (crc_stage)
   );

   chb_mix u_mix (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .mix_in  (crc_stage),
      .mix_out (mix_stage)
   );

   chb_out u_out (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .mix_in       (mix_stage),
      .out_valid    (rsp_chan.valid),
      .bucket_index (rsp_chan.bucket_index)
   );

endmodule

// ===== dv/tb.sv =====
// Testbench of the CRC-32 mix bucket hash unit: directed and random keys, scoreboard check.
`timescale 1ns / 1ps

module tb;
   import chb_pkg::*;

   localparam int CLOCK_HALF   = 6;
   localparam int RESET_CYCLES = 5;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_BYTES  = 100;
   localparam int REPORT_MAX   = 10;
   localparam int DIRECTED_ROWS = 18;

   typedef struct packed {
      logic [KEY_W-1:0]    key_byte;
      logic                last_byte;
      logic                pinned;
      logic [BUCKET_W-1:0] bucket;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   chb_req_if req_chan();
   chb_rsp_if rsp_chan();

   crc32_mix_bucket_hash_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   logic [BUCKET_W-1:0] pending_buckets[$];
   logic [BUCKET_W-1:0] head_bucket;
   logic [CRC_W-1:0]    key_crc = '0;
   logic                row_pinned;
   logic [BUCKET_W-1:0] row_bucket;
   int                  failure_count = 0;
   int                  cycle_count = 0;
   int                  send_idle_pct = 0;
   int                  recv_stall_pct = 0;

   // extremes, single and multi-byte keys; a zero CRC gives bucket zero
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, 10'd0},
      '{8'h00, 1'b0, 1'b0, 10'd0},
      '{8'h00, 1'b1, 1'b1, 10'd0},
      '{8'hFF, 1'b1, 1'b0, 10'd0},
      '{8'h01, 1'b1, 1'b0, 10'd0},
      '{8'h80, 1'b1, 1'b0, 10'd0},
      '{8'hFF, 1'b0, 1'b0, 10'd0},
      '{8'hFF, 1'b0, 1'b0, 10'd0},
      '{8'hFF, 1'b0, 1'b0, 10'd0},
      '{8'hFF, 1'b1, 1'b0, 10'd0},
      '{8'hAA, 1'b0, 1'b0, 10'd0},
      '{8'h55, 1'b1, 1'b0, 10'd0},
      '{8'h61, 1'b0, 1'b0, 10'd0},
      '{8'h62, 1'b0, 1'b0, 10'd0},
      '{8'h63, 1'b1, 1'b0, 10'd0},
      '{8'h00, 1'b0, 1'b0, 10'd0},
      '{8'hFF, 1'b1, 1'b0, 10'd0},
      '{8'h7F, 1'b1, 1'b0, 10'd0}
   };

   always begin
      #CLOCK_HALF clock = 1'b1;
      #CLOCK_HALF clock = 1'b0;
   end

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic logic [CRC_W-1:0] crc_advance(input logic [CRC_W-1:0] crc,
                                                    input logic [KEY_W-1:0] data);
      logic [CRC_W-1:0] c;
      c = {{(CRC_W-KEY_W){1'b0}}, crc[KEY_W-1:0] ^ data};
      for (int i = 0; i < 8; i++)
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c ^ (crc >> 8);
   endfunction

   function automatic logic [BUCKET_W-1:0] bucket_of_crc(input logic [CRC_W-1:0] crc);
      logic [MIX_W-1:0] k;
      k = {{(MIX_W-CRC_W){1'b0}}, crc};
      k += (k << 12);
      k ^= (k >> 22);
      k += (k << 4);
      k ^= (k >> 9);
      k += (k << 10);
      k ^= (k >> 2);
      k += (k << 7);
      k ^= (k >> 12);
      k = (k >> 3) * KNUTH_MULT;
      k = k % MIX_W'(TABLE_SIZE);
      return k[BUCKET_W-1:0];
   endfunction

   task automatic note_failure(input string msg);
      failure_count++;
      if (failure_count <= REPORT_MAX)
         $display("[%0t] %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (pending_buckets.size() == 0) begin
               note_failure($sformatf("unexpected item: bucket_index %0d",
                                      rsp_chan.bucket_index));
            end else begin
               head_bucket = pending_buckets.pop_front();
               if (rsp_chan.bucket_index !== head_bucket)
                  note_failure($sformatf("bucket_index mismatch: expected %0d, actual %0d",
                                         head_bucket, rsp_chan.bucket_index));
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            key_crc = crc_advance(key_crc, req_chan.key_byte);
            if (req_chan.last_byte) begin
               pending_buckets.push_back(row_pinned ? row_bucket : bucket_of_crc(key_crc));
               key_crc = '0;
            end
         end
      end
   end

   task automatic send_item(input logic [KEY_W-1:0] data, input logic last,
                            input logic pin, input logic [BUCKET_W-1:0] bkt);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.key_byte  <= data;
      req_chan.last_byte <= last;
      row_pinned         <= pin;
      row_bucket         <= bkt;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending_buckets.size() != 0) @(posedge clock);
   endtask

   task automatic send_random_keys(input int idle_pct, input int stall_pct);
      int sent;
      int key_len;
      logic [KEY_W-1:0] data;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < PHASE_BYTES) begin
         key_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
         for (int j = 0; j < key_len; j++) begin
            case ($urandom_range(7))
               0: data = '0;
               1: data = '1;
               default: data = KEY_W'($urandom);
            endcase
            send_item(data, j == key_len - 1, 1'b0, '0);
         end
         sent += key_len;
      end
      drain_results();
   endtask

   initial begin
      req_chan.valid     <= 1'b0;
      req_chan.key_byte  <= '0;
      req_chan.last_byte <= 1'b0;
      row_pinned         <= 1'b0;
      row_bucket         <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[r])
         send_item(directed_rows[r].key_byte, directed_rows[r].last_byte,
                   directed_rows[r].pinned, directed_rows[r].bucket);
      drain_results();

      send_random_keys(0, 0);
      send_random_keys(79, 0);
      send_random_keys(0, 79);
      send_random_keys(19, 19);

      recv_stall_pct = 0;
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_buckets.size() != 0)
         note_failure($sformatf("%0d expected items never arrived", pending_buckets.size()));

      if (failure_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

endmodule
